// File: hw/rtl/rbei_pkg.sv
// Shared types, codes and saturation helpers for the rigid body integrator.
`timescale 1ns / 1ps
`default_nettype none
package rbei_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LMUL,
    ST_LACC,
    ST_SMUL,
    ST_SACC,
    ST_QLO,
    ST_QHI,
    ST_QUPD,
    ST_QSQ,
    ST_QSACC,
    ST_ROOT,
    ST_DIVINIT,
    ST_DIV,
    ST_DIVWR,
    ST_OUT
  } state_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INV_MASS    = 2'd0;
  localparam cfg_idx_t CFG_INV_INERTIA = 2'd1;
  localparam cfg_idx_t CFG_FIXED       = 2'd2;

  // Per-axis operation codes
  typedef logic [2:0] axis_op_t;
  localparam axis_op_t OP_LMOM = 3'd0;
  localparam axis_op_t OP_VEL  = 3'd1;
  localparam axis_op_t OP_POS  = 3'd2;
  localparam axis_op_t OP_AMOM = 3'd3;
  localparam axis_op_t OP_OMEGA = 3'd4;

  localparam int MulW = 33;
  localparam int ProdW = 2 * MulW;
  localparam int WideW = 72;
  localparam int SpinW = 49;

  typedef struct packed {
    logic [1:0] w_sel;
    logic [1:0] q_sel;
    logic [1:0] t_sel;
    logic       neg;
  } spin_term_t;

  // (0,w)*q expanded into twelve signed product terms
  function automatic spin_term_t spin_term(input logic [3:0] j);
    spin_term_t s;
    case (j)
      4'd0:    s = '{w_sel: 2'd0, q_sel: 2'd1, t_sel: 2'd0, neg: 1'b1};
      4'd1:    s = '{w_sel: 2'd1, q_sel: 2'd2, t_sel: 2'd0, neg: 1'b1};
      4'd2:    s = '{w_sel: 2'd2, q_sel: 2'd3, t_sel: 2'd0, neg: 1'b1};
      4'd3:    s = '{w_sel: 2'd0, q_sel: 2'd0, t_sel: 2'd1, neg: 1'b0};
      4'd4:    s = '{w_sel: 2'd1, q_sel: 2'd3, t_sel: 2'd1, neg: 1'b0};
      4'd5:    s = '{w_sel: 2'd2, q_sel: 2'd2, t_sel: 2'd1, neg: 1'b1};
      4'd6:    s = '{w_sel: 2'd0, q_sel: 2'd3, t_sel: 2'd2, neg: 1'b1};
      4'd7:    s = '{w_sel: 2'd1, q_sel: 2'd0, t_sel: 2'd2, neg: 1'b0};
      4'd8:    s = '{w_sel: 2'd2, q_sel: 2'd1, t_sel: 2'd2, neg: 1'b0};
      4'd9:    s = '{w_sel: 2'd0, q_sel: 2'd2, t_sel: 2'd3, neg: 1'b0};
      4'd10:   s = '{w_sel: 2'd1, q_sel: 2'd1, t_sel: 2'd3, neg: 1'b1};
      4'd11:   s = '{w_sel: 2'd2, q_sel: 2'd0, t_sel: 2'd3, neg: 1'b0};
      default: s = '{w_sel: 2'd0, q_sel: 2'd0, t_sel: 2'd0, neg: 1'b0};
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_sym(input logic signed [WideW-1:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -72'sd2147483647) r = 32'sh80000001;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rbei_if.sv
// Valid/ready channel interfaces for step words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface rbei_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] torque_x;
  logic signed [31:0] torque_y;
  logic signed [31:0] torque_z;
  logic [15:0]        time_step;

  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  time_step, input ready);
  modport sink (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                time_step, output ready);
endinterface

interface rbei_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                vel_x, vel_y, vel_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rbei_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module rbei_mul
  import rbei_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [MulW-1:0]  a,
  input  wire logic signed [MulW-1:0]  b,
  output logic signed [ProdW-1:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

// File: hw/rtl/rigid_body_euler_integrator.sv
// Top level: rigid body Euler step sequencer around one shared multiplier.
// Sequence: per-axis momentum, velocity, position and angular updates, the
//   spin terms, the quaternion update, a one-bit square root loop and one-bit
//   divide loops; a fixed body runs only the velocity updates.
// Throughput: one step word at a time; no new step word is taken until the
//   result word of the last one has been taken.
// Reset: synchronous active-low rst_n clears the momenta and position, sets the
//   orientation to the identity and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_euler_integrator
  import rbei_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  rbei_in_if.sink         in_ch,
  rbei_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire cfg_idx_t   cfg_idx,
  input  wire logic [30:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // Configuration
  logic [30:0] invm_r, invi_r;
  logic        fixed_r;

  // Body state
  logic signed [31:0] lm_r [3];
  logic signed [31:0] am_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] w_r [3];
  logic signed [31:0] q_r [4];
  logic signed [SpinW-1:0] t_r [4];

  // Latched step word
  logic signed [31:0] f_r [3];
  logic signed [31:0] tq_r [3];
  logic [15:0]        dt_r;

  // Sequencer counters
  logic [1:0]  axis_r;
  axis_op_t    op_r;
  logic [3:0]  term_r;
  logic [1:0]  comp_r;
  logic [4:0]  cnt_r;

  // Datapath scratch
  logic signed [ProdW-1:0] acc_r;
  logic [63:0] sum_r;
  logic [63:0] x_r, res_r, bit_r;
  logic [33:0] rem_r;
  logic [30:0] quo_r;
  logic        dbit_r;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] p_r;

  spin_term_t  term;
  logic [1:0]  qi;
  logic signed [31:0] q_sel;
  logic signed [SpinW-1:0] t_cur;
  logic signed [MulW-1:0]  dt_op;

  logic signed [ProdW-1:0] sh16, sh17;
  logic signed [WideW-1:0] q_total;
  logic [63:0] root_trial;
  logic [32:0] q_mag;
  logic [34:0] div_trial;
  logic        accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign term   = spin_term(term_r);
  assign qi     = (state_r == ST_SMUL) ? term.q_sel : comp_r;
  assign q_sel  = q_r[qi];
  assign t_cur  = t_r[comp_r];
  assign dt_op  = MulW'($signed({1'b0, dt_r}));

  assign sh16 = p_r >>> 16;
  assign sh17 = p_r >>> 17;
  assign q_total = WideW'(acc_r) + (WideW'(p_r) <<< 24);
  assign root_trial = res_r + bit_r;
  assign q_mag = q_sel[31] ? 33'(-$signed({q_sel[31], q_sel})) : {1'b0, q_sel};
  assign div_trial = {rem_r, dbit_r};

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LMUL: begin
        case (op_r)
          OP_LMOM:  begin mul_a = MulW'(f_r[axis_r]);  mul_b = dt_op; end
          OP_VEL:   begin mul_a = MulW'(lm_r[axis_r]); mul_b = MulW'({2'b00, invm_r}); end
          OP_POS:   begin mul_a = MulW'(vel_r[axis_r]); mul_b = dt_op; end
          OP_AMOM:  begin mul_a = MulW'(tq_r[axis_r]); mul_b = dt_op; end
          OP_OMEGA: begin mul_a = MulW'(am_r[axis_r]); mul_b = MulW'({2'b00, invi_r}); end
          default:  begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SMUL: begin
        mul_a = MulW'(w_r[term.w_sel]);
        mul_b = MulW'(q_sel);
      end
      ST_QLO: begin
        mul_a = MulW'({9'd0, t_cur[23:0]});
        mul_b = dt_op;
      end
      ST_QHI: begin
        mul_a = MulW'($signed(t_cur[SpinW-1:24]));
        mul_b = dt_op;
      end
      ST_QSQ: begin
        mul_a = MulW'(q_sel);
        mul_b = MulW'(q_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rbei_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_LMUL;
      ST_LMUL:  state_nxt = ST_LACC;
      ST_LACC: begin
        if (fixed_r) begin
          state_nxt = (axis_r == 2'd2) ? ST_OUT : ST_LMUL;
        end else if (op_r == OP_OMEGA && axis_r == 2'd2) begin
          state_nxt = ST_SMUL;
        end else begin
          state_nxt = ST_LMUL;
        end
      end
      ST_SMUL:  state_nxt = ST_SACC;
      ST_SACC:  state_nxt = (term_r == 4'd11) ? ST_QLO : ST_SMUL;
      ST_QLO:   state_nxt = ST_QHI;
      ST_QHI:   state_nxt = ST_QUPD;
      ST_QUPD:  state_nxt = ST_QSQ;
      ST_QSQ:   state_nxt = ST_QSACC;
      ST_QSACC: state_nxt = (comp_r == 2'd3) ? ST_ROOT : ST_QLO;
      ST_ROOT:  state_nxt = (cnt_r == 5'd31) ? ST_DIVINIT : ST_ROOT;
      ST_DIVINIT: state_nxt = (res_r == '0) ? ST_OUT : ST_DIV;
      ST_DIV:   state_nxt = (cnt_r == 5'd30) ? ST_DIVWR : ST_DIV;
      ST_DIVWR: state_nxt = (comp_r == 2'd3) ? ST_OUT : ST_DIVINIT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Configuration writes: the sender writes only with no step in flight, which
  // the block itself does not enforce; out-of-range indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invm_r  <= 31'd65536;
      invi_r  <= 31'd65536;
      fixed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INV_MASS:    invm_r  <= cfg_wdata;
        CFG_INV_INERTIA: invi_r  <= cfg_wdata;
        CFG_FIXED:       fixed_r <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Datapath and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lm_r[i]  <= '0;
        am_r[i]  <= '0;
        pos_r[i] <= '0;
      end
      q_r[0] <= 32'sh40000000;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
      axis_r <= '0;
      op_r   <= OP_LMOM;
      term_r <= '0;
      comp_r <= '0;
      cnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            f_r[0]  <= in_ch.force_x;
            f_r[1]  <= in_ch.force_y;
            f_r[2]  <= in_ch.force_z;
            tq_r[0] <= in_ch.torque_x;
            tq_r[1] <= in_ch.torque_y;
            tq_r[2] <= in_ch.torque_z;
            dt_r    <= in_ch.time_step;
            axis_r  <= '0;
            // A fixed body only refreshes velocity
            op_r    <= fixed_r ? OP_VEL : OP_LMOM;
            term_r  <= '0;
            for (int i = 0; i < 4; i++) t_r[i] <= '0;
          end
        end
        ST_LACC: begin
          case (op_r)
            OP_LMOM:  lm_r[axis_r]  <= sat32(WideW'(lm_r[axis_r]) + WideW'(sh16));
            OP_VEL:   vel_r[axis_r] <= sat32(WideW'(sh16));
            OP_POS:   pos_r[axis_r] <= sat32(WideW'(pos_r[axis_r]) + WideW'(sh16));
            OP_AMOM:  am_r[axis_r]  <= sat32(WideW'(am_r[axis_r]) + WideW'(sh16));
            OP_OMEGA: w_r[axis_r]   <= sat32(WideW'(sh16));
            default:  ;
          endcase
          if (fixed_r || op_r == OP_OMEGA) begin
            axis_r <= axis_r + 2'd1;
            op_r   <= fixed_r ? OP_VEL : OP_LMOM;
          end else begin
            op_r <= op_r + 3'd1;
          end
        end
        ST_SACC: begin
          // Drop 17 bits: the product scale plus the one-half
          if (term.neg) t_r[term.t_sel] <= t_r[term.t_sel] - SpinW'(sh17);
          else          t_r[term.t_sel] <= t_r[term.t_sel] + SpinW'(sh17);
          term_r <= term_r + 4'd1;
          comp_r <= '0;
          sum_r  <= '0;
        end
        ST_QHI: begin
          acc_r <= p_r;
        end
        ST_QUPD: begin
          q_r[comp_r] <= sat32_sym(WideW'(q_r[comp_r]) + (q_total >>> 16));
        end
        ST_QSACC: begin
          sum_r  <= sum_r + p_r[63:0];
          x_r    <= sum_r + p_r[63:0];
          res_r  <= '0;
          bit_r  <= 64'h4000_0000_0000_0000;
          cnt_r  <= '0;
          comp_r <= comp_r + 2'd1;
        end
        ST_ROOT: begin
          if (x_r >= root_trial) begin
            x_r   <= x_r - root_trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
        end
        ST_DIVINIT: begin
          if (res_r == '0) begin
            q_r[0] <= 32'sh40000000;
            q_r[1] <= '0;
            q_r[2] <= '0;
            q_r[3] <= '0;
          end
          // Dividend is |q| shifted up by 30; its top bits never exceed the root
          rem_r  <= {2'b00, q_mag[32:1]};
          dbit_r <= q_mag[0];
          quo_r  <= '0;
          cnt_r  <= '0;
        end
        ST_DIV: begin
          if (div_trial >= {3'b000, res_r[31:0]}) begin
            rem_r <= 34'(div_trial - {3'b000, res_r[31:0]});
            quo_r <= {quo_r[29:0], 1'b1};
          end else begin
            rem_r <= div_trial[33:0];
            quo_r <= {quo_r[29:0], 1'b0};
          end
          dbit_r <= 1'b0;
          cnt_r  <= cnt_r + 5'd1;
        end
        ST_DIVWR: begin
          q_r[comp_r] <= q_sel[31] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
          comp_r      <= comp_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Result word straight from the body state, held until taken
  assign out_ch.valid  = (state_r == ST_OUT);
  assign out_ch.pos_x  = pos_r[0];
  assign out_ch.pos_y  = pos_r[1];
  assign out_ch.pos_z  = pos_r[2];
  assign out_ch.quat_w = q_r[0];
  assign out_ch.quat_x = q_r[1];
  assign out_ch.quat_y = q_r[2];
  assign out_ch.quat_z = q_r[3];
  assign out_ch.vel_x  = vel_r[0];
  assign out_ch.vel_y  = vel_r[1];
  assign out_ch.vel_z  = vel_r[2];

  // A result never waits while a new step is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("result and step accept overlap");

  // An accepted step never produces a result in the very next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_ch.valid)
    else $error("result too early after accept");

  // Normalized parts never exceed one in magnitude
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVWR) |-> (quo_r <= 31'h40000000))
    else $error("normalized quaternion part out of range");

  // The root loop ends with the probe bit consumed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && cnt_r == 5'd31) |=> (bit_r == '0))
    else $error("square root loop count mismatch");

endmodule
`default_nettype wire

// File: tb/rigid_body_euler_integrator_test.sv
// Self-checking bench for the rigid body Euler integrator: stepped body model and result queue.
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_euler_integrator_test
  import rbei_pkg::*;
();

  typedef struct {
    logic signed [31:0] fx, fy, fz, tx, ty, tz;
    logic [15:0]        dt;
  } step_word_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] quat [4];
    logic signed [31:0] vel [3];
  } pose_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_INV_MASS;
  logic [30:0] cfg_wdata = '0;

  rbei_in_if  in_ch ();
  rbei_out_if out_ch ();

  rigid_body_euler_integrator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Body model: mirror of the state kept in the block.
  logic [30:0]        mdl_inv_mass, mdl_inv_inertia;
  logic               mdl_fixed;
  logic signed [31:0] mdl_lmom [3], mdl_amom [3], mdl_pos [3], mdl_quat [4];

  pose_word_t expected_poses [$];
  int  fail_count = 0;
  bit  idle_sink = 1'b1;   // cleared in the last part of the run

  function automatic longint fshr(longint v, int s);
    return v >>> s;        // arithmetic shift floors for signed operands
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clip_sym(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483647) return 32'sh80000001;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] body_velocity(int i);
    return clip(fshr(longint'(mdl_lmom[i]) * longint'({1'b0, mdl_inv_mass}), 16));
  endfunction

  task automatic model_reset();
    mdl_inv_mass = 31'd65536;
    mdl_inv_inertia = 31'd65536;
    mdl_fixed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mdl_lmom[i] = 0; mdl_amom[i] = 0; mdl_pos[i] = 0;
    end
    mdl_quat[0] = 32'sh40000000;
    for (int i = 1; i < 4; i++) mdl_quat[i] = 0;
  endtask

  // Advance the body by one step and queue the pose word it reports.
  task automatic predict_pose(step_word_t s);
    longint dt, f[3], tq[3], w[3], q[4], t[4];
    longint unsigned sq, nrm;
    pose_word_t p;
    dt = longint'(s.dt);
    f[0] = s.fx; f[1] = s.fy; f[2] = s.fz;
    tq[0] = s.tx; tq[1] = s.ty; tq[2] = s.tz;
    if (!mdl_fixed) begin
      for (int i = 0; i < 3; i++) begin
        mdl_lmom[i] = clip(longint'(mdl_lmom[i]) + fshr(f[i] * dt, 16));
        mdl_pos[i] = clip(longint'(mdl_pos[i])
                          + fshr(longint'(body_velocity(i)) * dt, 16));
        mdl_amom[i] = clip(longint'(mdl_amom[i]) + fshr(tq[i] * dt, 16));
        w[i] = clip(fshr(longint'(mdl_amom[i]) * longint'({1'b0, mdl_inv_inertia}), 16));
      end
      for (int i = 0; i < 4; i++) q[i] = mdl_quat[i];
      t[0] = -fshr(w[0]*q[1], 17) - fshr(w[1]*q[2], 17) - fshr(w[2]*q[3], 17);
      t[1] =  fshr(w[0]*q[0], 17) + fshr(w[1]*q[3], 17) - fshr(w[2]*q[2], 17);
      t[2] = -fshr(w[0]*q[3], 17) + fshr(w[1]*q[0], 17) + fshr(w[2]*q[1], 17);
      t[3] =  fshr(w[0]*q[2], 17) - fshr(w[1]*q[1], 17) + fshr(w[2]*q[0], 17);
      sq = 0;
      for (int i = 0; i < 4; i++) begin
        q[i] = clip_sym(q[i] + fshr(t[i] * dt, 16));
        sq = sq + longint'(q[i] * q[i]);
      end
      nrm = floor_root(sq);
      if (nrm == 0) begin
        // degenerate orientation falls back to the identity
        mdl_quat[0] = 32'sh40000000;
        for (int i = 1; i < 4; i++) mdl_quat[i] = 0;
      end else begin
        for (int i = 0; i < 4; i++)
          mdl_quat[i] = clip((q[i] * 64'sd1073741824) / longint'(nrm));
      end
    end
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = mdl_pos[i];
      p.vel[i] = body_velocity(i);
    end
    for (int i = 0; i < 4; i++) p.quat[i] = mdl_quat[i];
    expected_poses = {expected_poses, p};
  endtask

  // Sender: hold the word until accepted; drop valid only for a random gap.
  bit idle_source = 1'b1;

  task automatic send_step(step_word_t s);
    if (idle_source && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.force_x <= s.fx; in_ch.force_y <= s.fy; in_ch.force_z <= s.fz;
    in_ch.torque_x <= s.tx; in_ch.torque_y <= s.ty; in_ch.torque_z <= s.tz;
    in_ch.time_step <= s.dt;
    do @(posedge clk); while (!in_ch.ready);
    predict_pose(s);
  endtask

  // Result checker and random stall on the result side.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_poses.size() == 0) begin
        $error("pose word with nothing expected");
        fail_count++;
      end else begin
        pose_word_t e;
        e = expected_poses.pop_front();
        if (out_ch.pos_x !== e.pos[0]) begin
          $error("pos_x expected %0d got %0d", e.pos[0], out_ch.pos_x); fail_count++;
        end
        if (out_ch.pos_y !== e.pos[1]) begin
          $error("pos_y expected %0d got %0d", e.pos[1], out_ch.pos_y); fail_count++;
        end
        if (out_ch.pos_z !== e.pos[2]) begin
          $error("pos_z expected %0d got %0d", e.pos[2], out_ch.pos_z); fail_count++;
        end
        if (out_ch.quat_w !== e.quat[0]) begin
          $error("quat_w expected %0d got %0d", e.quat[0], out_ch.quat_w); fail_count++;
        end
        if (out_ch.quat_x !== e.quat[1]) begin
          $error("quat_x expected %0d got %0d", e.quat[1], out_ch.quat_x); fail_count++;
        end
        if (out_ch.quat_y !== e.quat[2]) begin
          $error("quat_y expected %0d got %0d", e.quat[2], out_ch.quat_y); fail_count++;
        end
        if (out_ch.quat_z !== e.quat[3]) begin
          $error("quat_z expected %0d got %0d", e.quat[3], out_ch.quat_z); fail_count++;
        end
        if (out_ch.vel_x !== e.vel[0]) begin
          $error("vel_x expected %0d got %0d", e.vel[0], out_ch.vel_x); fail_count++;
        end
        if (out_ch.vel_y !== e.vel[1]) begin
          $error("vel_y expected %0d got %0d", e.vel[1], out_ch.vel_y); fail_count++;
        end
        if (out_ch.vel_z !== e.vel[2]) begin
          $error("vel_z expected %0d got %0d", e.vel[2], out_ch.vel_z); fail_count++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_sink && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Drop valid and wait for the block to drain before touching a register.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INV_MASS) mdl_inv_mass = val;
    else if (idx == CFG_INV_INERTIA) mdl_inv_inertia = val;
    else if (idx == CFG_FIXED) mdl_fixed = val[0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 4096) - 2048;
      3: return ($urandom_range(0, 1 << 20) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic step_word_t rand_step(bit gentle);
    step_word_t s;
    if (gentle) begin
      // moderate forces keep the body in a meaningful range
      s.fx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      s.fy = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      s.fz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      s.tx = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      s.ty = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      s.tz = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      s.dt = 16'($urandom_range(0, 4000));
    end else begin
      s.fx = rand_val(); s.fy = rand_val(); s.fz = rand_val();
      s.tx = rand_val(); s.ty = rand_val(); s.tz = rand_val();
      s.dt = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
    end
    return s;
  endfunction

  function automatic step_word_t make_step(logic [31:0] f, logic [31:0] t, logic [15:0] d);
    step_word_t s;
    s.fx = f; s.fy = -f; s.fz = f;
    s.tx = t; s.ty = t; s.tz = -t;
    s.dt = d;
    return s;
  endfunction

  // Directed: field extremes, zero step, saturation.
  task automatic test_extremes();
    send_step(make_step(32'h0, 32'h0, 16'h0));
    send_step(make_step(32'h00010000, 32'h00008000, 16'h1000));
    send_step(make_step(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
    send_step(make_step(32'h80000000, 32'h80000000, 16'hFFFF));
    send_step(make_step(32'h7FFFFFFF, 32'h80000000, 16'hFFFF));
    send_step(make_step(32'hFFFFFFFF, 32'h00000001, 16'h0001));
    send_step(make_step(32'h55555555, 32'hAAAAAAAA, 16'h5555));
    send_step(make_step(32'hAAAAAAAA, 32'h55555555, 16'hAAAA));
    drain();
  endtask

  // Fixed body: state frozen, velocity from stored momentum.
  task automatic test_fixed_body();
    write_reg(CFG_FIXED, 31'd1);
    send_step(make_step(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
    send_step(make_step(32'h80000000, 32'h12345678, 16'h8000));
    drain();
    write_reg(CFG_INV_MASS, 31'h7FFFFFFF);
    send_step(make_step(32'h0, 32'h0, 16'h0));
    drain();
    write_reg(CFG_FIXED, 31'd0);
    write_reg(CFG_INV_MASS, 31'd65536);
  endtask

  // Mass and inertia at their extremes, including zero.
  task automatic test_register_extremes();
    logic [30:0] vals [4] = '{31'd0, 31'h7FFFFFFF, 31'd1, 31'd65536};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_INV_MASS, vals[k]);
      write_reg(CFG_INV_INERTIA, vals[3 - k]);
      write_reg(CFG_FIXED, 31'h7FFFFFFE);   // bit 0 only counts
      send_step(make_step(32'h00020000, 32'h00100000, 16'h4000));
      send_step(make_step(32'hFFFE0000, 32'h7FFFFFFF, 16'hFFFF));
      drain();
    end
  endtask

  task automatic test_random(int n, bit gentle_mostly);
    step_word_t s;
    for (int i = 0; i < n; i++) begin
      s = rand_step(gentle_mostly ? ($urandom_range(0, 9) != 0) : 1'b0);
      send_step(s);
      // pause the sender until every pose word has come back
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.force_x <= '0; in_ch.force_y <= '0; in_ch.force_z <= '0;
    in_ch.torque_x <= '0; in_ch.torque_y <= '0; in_ch.torque_z <= '0;
    in_ch.time_step <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    model_reset();
    @(posedge clk);
    test_extremes();
    test_fixed_body();
    test_register_extremes();
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(CFG_INV_MASS, (phase == 4) ? 31'd65536 : 31'($urandom_range(0, 1 << 18)));
      write_reg(CFG_INV_INERTIA, 31'($urandom_range(0, 1 << 17)));
      write_reg(CFG_FIXED, {30'd0, 1'(phase == 2)});
      test_random(300, phase != 3);
    end
    // last part: no idling on either side
    idle_source = 1'b0;
    idle_sink = 1'b0;
    write_reg(CFG_FIXED, 31'd0);
    test_random(300, 1'b1);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expected_poses.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Run limit: room for the 1819 step words plus stalls, several times over.
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
